[design/cmt_pkg.sv]
package cmt_pkg;

	// Input command codes
	localparam logic [2:0] CMD_SEC_TICK   = 3'd0;
	localparam logic [2:0] CMD_BLINK_TICK = 3'd1;
	localparam logic [2:0] CMD_SET        = 3'd2;
	localparam logic [2:0] CMD_MODE       = 3'd3;
	localparam logic [2:0] CMD_TOGGLE     = 3'd4;
	localparam logic [2:0] CMD_ALARM_BTN  = 3'd5;
	localparam logic [2:0] CMD_RTC_ALARM  = 3'd6;

	// Operating modes, as reported on the result
	localparam logic [2:0] MODE_CLOCK     = 3'd0;
	localparam logic [2:0] MODE_EDIT      = 3'd1;
	localparam logic [2:0] MODE_STOPWATCH = 3'd2;
	localparam logic [2:0] MODE_CD_SET    = 3'd3;
	localparam logic [2:0] MODE_CD_RUN    = 3'd4;

	// Requests to the real-time clock
	localparam logic [1:0] ACT_NONE        = 2'd0;
	localparam logic [1:0] ACT_WRITE_TIME  = 2'd1;
	localparam logic [1:0] ACT_WRITE_ALARM = 2'd2;
	localparam logic [1:0] ACT_ALARM_OFF   = 2'd3;

	localparam logic [4:0] LAST_HOUR  = 5'd23;
	localparam logic [5:0] LAST_DIGIT = 6'd59;

	localparam int IN_DATA_W  = 24;
	localparam int IN_USER_W  = 4;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [2:0] {
		OP_SEC_TICK   = 3'd0,
		OP_BLINK_TICK = 3'd1,
		OP_SET        = 3'd2,
		OP_MODE       = 3'd3,
		OP_TOGGLE     = 3'd4,
		OP_ALARM_BTN  = 3'd5,
		OP_RTC_ALARM  = 3'd6,
		OP_NONE       = 3'd7
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       long_press;
		logic [4:0] rtc_hours;
		logic [5:0] rtc_minutes;
		logic [5:0] rtc_seconds;
	} item_t;

	// Lowest field last, so that mode sits in the low bits when packed
	typedef struct packed {
		logic [1:0] rtc_action;
		logic       led;
		logic       buzzer;
		logic       alarm_armed;
		logic       ringing;
		logic       blink_phase;
		logic       selection;
		logic       view;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic [2:0] mode;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

	function automatic logic [5:0] inc_wrap6(input logic [5:0] v, input logic [5:0] last);
		return (v >= last) ? 6'd0 : v + 6'd1;
	endfunction

	function automatic logic [4:0] inc_wrap5(input logic [4:0] v, input logic [4:0] last);
		return (v >= last) ? 5'd0 : v + 5'd1;
	endfunction

endpackage

[design/clock_timer_mode_controller_top.sv]
// Clock, stopwatch and countdown mode controller. One event per input transfer (second tick,
// blink tick, set/mode/toggle/alarm button with long-press flag, or rtc alarm) gives exactly
// one result transfer carrying the full state after that event plus one request for the
// real-time clock. Events may follow back to back while results are taken: an input register
// and a two-entry queue feed the execution stage, whose state update is the only loop, and
// it fires only while the result register is empty or its result is being taken. Each event
// passes the input register, a queue slot and the result register, in that order.
// Reset puts the block in clock mode, digits zero, minutes:seconds view, all flags clear.
module clock_timer_mode_controller_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// rtc_hours[4:0], rtc_minutes[10:5], rtc_seconds[16:11], zeros above
	input  logic [23:0] s_tdata,
	// cmd[2:0], long_press[3]
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// mode[2:0], hours[7:3], minutes[13:8], seconds[19:14], view[20], selection[21],
	// blink_phase[22], ringing[23], alarm_armed[24], buzzer[25], led[26],
	// rtc_action[28:27], zeros above
	output logic [31:0] m_tdata
);
	import cmt_pkg::*;

	logic  push;
	logic  push_ready;
	item_t push_item;
	logic  pop_valid;
	logic  pop;
	item_t pop_item;

	cmt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready)
	);

	cmt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop        (pop)
	);

	cmt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (pop_valid),
		.item       (pop_item),
		.item_pop   (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

[design/cmt_front.sv]
module cmt_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// rtc_hours[4:0], rtc_minutes[10:5], rtc_seconds[16:11], zero fill
	input  logic [cmt_pkg::IN_DATA_W-1:0] s_tdata,
	// cmd[2:0], long_press[3]
	input  logic [cmt_pkg::IN_USER_W-1:0] s_tuser,
	output logic                         push,
	output cmt_pkg::item_t               push_item,
	input  logic                         push_ready
);
	import cmt_pkg::*;

	logic  valid_s1;
	item_t item_s1;
	op_t   op_dec;

	always_comb begin
		unique case (s_tuser[2:0])
			CMD_SEC_TICK:   op_dec = OP_SEC_TICK;
			CMD_BLINK_TICK: op_dec = OP_BLINK_TICK;
			CMD_SET:        op_dec = OP_SET;
			CMD_MODE:       op_dec = OP_MODE;
			CMD_TOGGLE:     op_dec = OP_TOGGLE;
			CMD_ALARM_BTN:  op_dec = OP_ALARM_BTN;
			CMD_RTC_ALARM:  op_dec = OP_RTC_ALARM;
			default:        op_dec = OP_NONE;
		endcase
	end

	assign s_tready  = !valid_s1 || push_ready;
	assign push      = valid_s1;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op          <= op_dec;
			item_s1.long_press  <= s_tuser[3];
			item_s1.rtc_hours   <= s_tdata[4:0];
			item_s1.rtc_minutes <= s_tdata[10:5];
			item_s1.rtc_seconds <= s_tdata[16:11];
		end
	end

endmodule

[design/cmt_queue.sv]
module cmt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cmt_pkg::item_t push_item,
	output logic           push_ready,
	output logic           pop_valid,
	output cmt_pkg::item_t pop_item,
	input  logic           pop
);
	import cmt_pkg::*;

	item_t      slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_item   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop)  rd_ptr_q <= !rd_ptr_q;
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

[design/cmt_core.sv]
module cmt_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	input  cmt_pkg::item_t                item,
	output logic                          item_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [cmt_pkg::OUT_DATA_W-1:0] m_tdata
);
	import cmt_pkg::*;

	logic [2:0] mode_q, n_mode;
	logic [4:0] hours_q, n_hours;
	logic [5:0] minutes_q, n_minutes;
	logic [5:0] seconds_q, n_seconds;
	logic       view_q, n_view;
	logic       sel_q, n_sel;
	logic       blink_q, n_blink;
	logic       ring_q, n_ring;
	logic       armed_q, n_armed;
	logic       buzz_q, n_buzz;
	logic       led_q, n_led;
	logic [1:0] n_action;

	logic    out_valid_q;
	result_t out_q;
	logic    fire;

	assign fire     = item_valid && (!out_valid_q || m_tready);
	assign item_pop = fire;

	always_comb begin
		n_mode    = mode_q;
		n_hours   = hours_q;
		n_minutes = minutes_q;
		n_seconds = seconds_q;
		n_view    = view_q;
		n_sel     = sel_q;
		n_blink   = blink_q;
		n_ring    = ring_q;
		n_armed   = armed_q;
		n_buzz    = buzz_q;
		n_led     = led_q;
		n_action  = ACT_NONE;

		unique case (item.op)
			OP_SEC_TICK: begin
				if (mode_q == MODE_STOPWATCH) begin
					n_seconds = inc_wrap6(seconds_q, LAST_DIGIT);
					if (seconds_q >= LAST_DIGIT) begin
						n_minutes = inc_wrap6(minutes_q, LAST_DIGIT);
						if (minutes_q >= LAST_DIGIT)
							n_hours = inc_wrap5(hours_q, LAST_HOUR);
					end
				end else if (mode_q == MODE_CD_RUN && !ring_q) begin
					// a borrow from a higher pair refills every lower pair
					if (seconds_q != 6'd0) begin
						n_seconds = seconds_q - 6'd1;
					end else if (minutes_q != 6'd0) begin
						n_minutes = minutes_q - 6'd1;
						n_seconds = LAST_DIGIT;
					end else if (hours_q != 5'd0) begin
						n_hours   = hours_q - 5'd1;
						n_minutes = LAST_DIGIT;
						n_seconds = LAST_DIGIT;
					end
					if (n_seconds == 6'd0 && n_minutes == 6'd0 && n_hours == 5'd0)
						n_ring = 1'b1;
				end
			end
			OP_BLINK_TICK: begin
				if (mode_q == MODE_CLOCK || mode_q == MODE_STOPWATCH ||
				    mode_q == MODE_CD_RUN) begin
					if (mode_q == MODE_CLOCK) begin
						n_hours   = item.rtc_hours;
						n_minutes = item.rtc_minutes;
						n_seconds = item.rtc_seconds;
					end
					if (!view_q || ring_q) begin
						n_blink = !blink_q;
						// sound on the low half of the blink
						if (ring_q) begin
							n_buzz = blink_q;
							n_led  = blink_q;
						end
					end
				end else if (mode_q == MODE_EDIT || mode_q == MODE_CD_SET) begin
					n_blink = !blink_q;
				end
			end
			OP_SET: begin
				if (mode_q == MODE_CLOCK) begin
					n_mode  = MODE_EDIT;
					n_blink = 1'b0;
				end else if (mode_q == MODE_EDIT) begin
					n_action = ACT_WRITE_TIME;
					n_mode   = MODE_CLOCK;
					n_blink  = 1'b0;
					n_sel    = 1'b0;
				end else if (mode_q == MODE_STOPWATCH) begin
					n_hours   = '0;
					n_minutes = '0;
					n_seconds = '0;
				end
			end
			OP_MODE: begin
				if (mode_q == MODE_CLOCK) begin
					n_mode    = MODE_STOPWATCH;
					n_hours   = '0;
					n_minutes = '0;
					n_seconds = '0;
				end else if (mode_q == MODE_STOPWATCH) begin
					n_mode    = MODE_CD_SET;
					n_hours   = '0;
					n_minutes = '0;
					n_seconds = '0;
				end else if (mode_q == MODE_CD_SET) begin
					if (item.long_press) begin
						n_mode  = MODE_CD_RUN;
						n_led   = 1'b1;
						n_armed = 1'b1;
					end
				end else if (mode_q == MODE_CD_RUN) begin
					n_mode    = MODE_CLOCK;
					n_led     = 1'b0;
					n_buzz    = 1'b0;
					n_ring    = 1'b0;
					n_armed   = 1'b0;
					n_hours   = item.rtc_hours;
					n_minutes = item.rtc_minutes;
					n_seconds = item.rtc_seconds;
				end
				// selection flips in whichever editing mode is now current
				if (n_mode == MODE_EDIT || n_mode == MODE_CD_SET)
					n_sel = !sel_q;
			end
			OP_TOGGLE: begin
				if (mode_q == MODE_CLOCK || mode_q == MODE_STOPWATCH ||
				    mode_q == MODE_CD_RUN) begin
					n_view = !view_q;
					if (mode_q == MODE_STOPWATCH) begin
						n_hours   = '0;
						n_minutes = '0;
						n_seconds = '0;
					end
				end else if (mode_q == MODE_EDIT || mode_q == MODE_CD_SET) begin
					unique case ({view_q, sel_q})
						2'b00:   n_hours   = inc_wrap5(hours_q, LAST_HOUR);
						2'b01,
						2'b10:   n_minutes = inc_wrap6(minutes_q, LAST_DIGIT);
						default: n_seconds = inc_wrap6(seconds_q, LAST_DIGIT);
					endcase
				end
			end
			OP_ALARM_BTN: begin
				if (mode_q == MODE_CLOCK) begin
					if (item.long_press) n_armed = 1'b0;
					n_ring = 1'b0;
					n_buzz = 1'b0;
					if (!n_armed) begin
						n_action = ACT_ALARM_OFF;
						n_led    = 1'b0;
					end
				end else if (mode_q == MODE_EDIT) begin
					n_action  = ACT_WRITE_ALARM;
					n_led     = 1'b1;
					n_armed   = 1'b1;
					n_mode    = MODE_CLOCK;
					n_blink   = 1'b0;
					n_sel     = 1'b0;
					n_hours   = item.rtc_hours;
					n_minutes = item.rtc_minutes;
					n_seconds = item.rtc_seconds;
				end
			end
			OP_RTC_ALARM: begin
				if (mode_q == MODE_CLOCK) n_ring = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_CLOCK;
			hours_q     <= '0;
			minutes_q   <= '0;
			seconds_q   <= '0;
			view_q      <= 1'b1;
			sel_q       <= 1'b0;
			blink_q     <= 1'b0;
			ring_q      <= 1'b0;
			armed_q     <= 1'b0;
			buzz_q      <= 1'b0;
			led_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				mode_q    <= n_mode;
				hours_q   <= n_hours;
				minutes_q <= n_minutes;
				seconds_q <= n_seconds;
				view_q    <= n_view;
				sel_q     <= n_sel;
				blink_q   <= n_blink;
				ring_q    <= n_ring;
				armed_q   <= n_armed;
				buzz_q    <= n_buzz;
				led_q     <= n_led;
			end
			if (fire)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q.mode        <= n_mode;
			out_q.hours       <= n_hours;
			out_q.minutes     <= n_minutes;
			out_q.seconds     <= n_seconds;
			out_q.view        <= n_view;
			out_q.selection   <= n_sel;
			out_q.blink_phase <= n_blink;
			out_q.ringing     <= n_ring;
			out_q.alarm_armed <= n_armed;
			out_q.buzzer      <= n_buzz;
			out_q.led         <= n_led;
			out_q.rtc_action  <= n_action;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_q};

`ifndef SYNTHESIS
	// the buzzer only ever sounds while ringing
	a_buzz_needs_ring: assert property (@(posedge clk) disable iff (!arst_n)
		buzz_q |-> ring_q)
		else $error("buzzer on while not ringing");

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q <= MODE_CD_RUN)
		else $error("mode register out of range");

	// any clock write or alarm request leaves the block back in clock mode
	a_action_in_clock: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.rtc_action != ACT_NONE) |-> out_q.mode == MODE_CLOCK)
		else $error("rtc request outside clock mode");

	a_no_fire_without_item: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (out_valid_q && out_q.mode == $past(n_mode)))
		else $error("result register lost an update");
`endif

endmodule
